// ----- rtl/erc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package erc_pkg;

  localparam int QueueDepthDef = 16;
  localparam int FloorCount    = 16;
  localparam int FloorWidth    = 4;
  localparam int CountWidth    = 5;
  localparam logic [CountWidth-1:0] QueueLimitRst = 5'd10;

  typedef enum logic [2:0] {
    OP_REQUEST   = 3'd0,
    OP_START     = 3'd1,
    OP_STEP      = 3'd2,
    OP_STOP      = 3'd3,
    OP_EMERG_ON  = 3'd4,
    OP_EMERG_OFF = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DUPLICATE = 3'd1,
    EV_STARTED   = 3'd2,
    EV_PASSED    = 3'd3,
    EV_STOPPED   = 3'd4,
    EV_WARNING   = 3'd5,
    EV_RESUME    = 3'd6
  } event_e;

endpackage

`default_nettype wire

// ----- rtl/elevator_request_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Each word is registered on accept, when the RAM read is issued, and executed in ST_EXEC once the output is free.
// Only one word at a time: no new word is accepted while ST_EXEC holds the last one.
// A finished result waits in the output register; the next word is taken meanwhile.
// Reset: async active low; car at floor 0, queue empty, queue_limit 10.
// Queue RAM contents are not cleared; only written entries are read.
module elevator_request_controller
  import erc_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CountWidth-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [2:0]            op_i,
  input  wire logic [FloorWidth-1:0] floor_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [2:0]                 event_res_o,
  output logic [CountWidth-1:0]      event_floor_o,
  output logic                       arrived_o,
  output logic                       motor_cw_o,
  output logic                       motor_on_o,
  output logic [FloorWidth-1:0]      current_floor_o,
  output logic [FloorWidth-1:0]      target_floor_o,
  output logic [CountWidth-1:0]      pending_o,
  output logic                       alarm_o
);

  localparam int IdxWidth = $clog2(QueueDepth);
  localparam int LimWidth = $clog2(QueueDepth + 1) > CountWidth ?
                            $clog2(QueueDepth + 1) : CountWidth;
  localparam int FlWidth  = $clog2(FloorCount + 1) > FloorWidth ?
                            $clog2(FloorCount + 1) : FloorWidth;
  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(QueueDepth - 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                 state_q;
  logic [2:0]             op_q;
  logic [FloorWidth-1:0]  floor_q;
  logic [CountWidth-1:0]  limit_q;
  logic [FloorWidth-1:0]  car_q, car_d;
  logic [FloorWidth-1:0]  goal_q, goal_d;
  logic                   moving_q, moving_d;
  logic                   emerg_q, emerg_d;
  logic                   dir_up_q, dir_up_d;
  logic [IdxWidth-1:0]    head_q, head_d;
  logic [IdxWidth-1:0]    tail_q, tail_d;
  logic [LimWidth-1:0]    count_q, count_d;

  logic                   out_valid_q;
  logic [2:0]             ev_q, ev_d;
  logic [CountWidth-1:0]  evf_q, evf_d;
  logic                   arr_q, arr_d;

  logic                   in_acc;
  logic                   exec_go;
  logic [IdxWidth-1:0]    tail_prev;
  logic [IdxWidth-1:0]    raddr;
  logic [FloorWidth-1:0]  rdata;
  logic                   ram_we;
  logic [LimWidth-1:0]    lim;
  logic                   req_drop;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign exec_go    = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  assign tail_prev = (tail_q == '0) ? LastIdx : tail_q - 1'b1;
  assign raddr     = (op_e'(op_i) == OP_START) ? head_q : tail_prev;

  erc_ram #(
    .Width(FloorWidth),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(floor_q),
    .re_i   (in_acc),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign lim = (LimWidth'(limit_q) > LimWidth'(QueueDepth)) ?
               LimWidth'(QueueDepth) : LimWidth'(limit_q);
  assign req_drop = emerg_q || (count_q >= lim) ||
                    (FlWidth'(floor_q) >= FlWidth'(FloorCount));

  always_comb begin
    car_d    = car_q;
    goal_d   = goal_q;
    moving_d = moving_q;
    emerg_d  = emerg_q;
    dir_up_d = dir_up_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    ev_d     = EV_NONE;
    evf_d    = '0;
    arr_d    = 1'b0;
    ram_we   = 1'b0;
    case (op_e'(op_q))
      OP_REQUEST: begin
        if (!req_drop) begin
          if (count_q != '0 && rdata == floor_q) begin
            ev_d  = EV_DUPLICATE;
            evf_d = CountWidth'(floor_q) + 1'b1;
          end else if (!(count_q == '0 && car_q == floor_q)) begin
            ram_we  = exec_go;
            tail_d  = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
            count_d = count_q + 1'b1;
          end
        end
      end
      OP_START: begin
        if (count_q != '0) begin
          goal_d   = rdata;
          moving_d = 1'b1;
          dir_up_d = rdata > car_q;
          ev_d     = EV_STARTED;
          evf_d    = CountWidth'(rdata) + 1'b1;
        end
      end
      OP_STEP: begin
        if (car_q < goal_q) begin
          car_d = car_q + 1'b1;
        end else if (car_q > goal_q) begin
          car_d = car_q - 1'b1;
        end
        ev_d  = EV_PASSED;
        evf_d = CountWidth'(car_d) + 1'b1;
        arr_d = (car_d == goal_q);
      end
      OP_STOP: begin
        moving_d = 1'b0;
        if (count_q != '0) begin
          head_d  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
        end
        ev_d = EV_STOPPED;
      end
      OP_EMERG_ON: begin
        emerg_d  = 1'b1;
        goal_d   = car_q;
        moving_d = 1'b0;
        head_d   = '0;
        tail_d   = '0;
        count_d  = '0;
        ev_d     = EV_WARNING;
      end
      OP_EMERG_OFF: begin
        emerg_d = 1'b0;
        ev_d    = EV_RESUME;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      floor_q     <= '0;
      limit_q     <= QueueLimitRst;
      car_q       <= '0;
      goal_q      <= '0;
      moving_q    <= 1'b0;
      emerg_q     <= 1'b0;
      dir_up_q    <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ev_q        <= EV_NONE;
      evf_q       <= '0;
      arr_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && !exec_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q    <= op_i;
            floor_q <= floor_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            car_q       <= car_d;
            goal_q      <= goal_d;
            moving_q    <= moving_d;
            emerg_q     <= emerg_d;
            dir_up_q    <= dir_up_d;
            head_q      <= head_d;
            tail_q      <= tail_d;
            count_q     <= count_d;
            ev_q        <= ev_d;
            evf_q       <= evf_d;
            arr_q       <= arr_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = ev_q;
  assign event_floor_o   = evf_q;
  assign arrived_o       = arr_q;
  assign motor_cw_o      = dir_up_q;
  assign motor_on_o      = moving_q;
  assign current_floor_o = car_q;
  assign target_floor_o  = goal_q;
  assign pending_o       = CountWidth'(count_q);
  assign alarm_o         = emerg_q;

endmodule

`default_nettype wire

// ----- rtl/erc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module erc_ram #(
  parameter int Width = 4,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import erc_pkg::*;

  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldLen = 300;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    event_e                event_code;
    logic [CountWidth-1:0] event_floor;
    logic                  arrived;
    logic                  motor_cw;
    logic                  motor_on;
    logic [FloorWidth-1:0] car_floor;
    logic [FloorWidth-1:0] goal_fl;
    logic [CountWidth-1:0] pending;
    logic                  alarm;
  } car_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CountWidth-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [2:0]            op_i = '0;
  logic [FloorWidth-1:0] floor_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [2:0]            event_res_o;
  logic [CountWidth-1:0] event_floor_o;
  logic                  arrived_o;
  logic                  motor_cw_o;
  logic                  motor_on_o;
  logic [FloorWidth-1:0] current_floor_o;
  logic [FloorWidth-1:0] target_floor_o;
  logic [CountWidth-1:0] pending_o;
  logic                  alarm_o;

  elevator_request_controller DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .floor_i        (floor_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .event_floor_o  (event_floor_o),
    .arrived_o      (arrived_o),
    .motor_cw_o     (motor_cw_o),
    .motor_on_o     (motor_on_o),
    .current_floor_o(current_floor_o),
    .target_floor_o (target_floor_o),
    .pending_o      (pending_o),
    .alarm_o        (alarm_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // car state as predicted
  logic [FloorWidth-1:0] car_at = '0;
  logic [FloorWidth-1:0] goal_at = '0;
  logic                  car_moving = 1'b0;
  logic                  emerg_on = 1'b0;
  logic                  heading_up = 1'b0;
  logic [FloorWidth-1:0] floor_queue [QueueDepthDef];
  logic [3:0]            q_head = '0;
  logic [3:0]            q_tail = '0;
  logic [CountWidth-1:0] q_count = '0;
  logic [CountWidth-1:0] q_limit = QueueLimitRst;

  car_report_t reports_due [$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  function automatic car_report_t car_response(input logic [2:0] op,
                                               input logic [FloorWidth-1:0] fl);
    car_report_t r;
    logic [CountWidth-1:0] lim;
    logic [3:0] newest;
    r = '0;
    lim = (q_limit > CountWidth'(QueueDepthDef)) ? CountWidth'(QueueDepthDef) : q_limit;
    newest = q_tail - 4'd1;
    case (op)
      OP_REQUEST: begin
        if (!emerg_on && q_count < lim && fl < FloorCount) begin
          if (q_count != 0 && floor_queue[newest] == fl) begin
            r.event_code = EV_DUPLICATE;
            r.event_floor = {1'b0, fl} + 5'd1;
          end else if (!(q_count == 0 && car_at == fl)) begin
            floor_queue[q_tail] = fl;
            q_tail = q_tail + 4'd1;
            q_count = q_count + 5'd1;
          end
        end
      end
      OP_START: begin
        if (q_count != 0) begin
          goal_at = floor_queue[q_head];
          car_moving = 1'b1;
          heading_up = goal_at > car_at;
          r.event_code = EV_STARTED;
          r.event_floor = {1'b0, goal_at} + 5'd1;
        end
      end
      OP_STEP: begin
        if (car_at < goal_at) car_at = car_at + 4'd1;
        else if (car_at > goal_at) car_at = car_at - 4'd1;
        r.event_code = EV_PASSED;
        r.event_floor = {1'b0, car_at} + 5'd1;
        r.arrived = car_at == goal_at;
      end
      OP_STOP: begin
        car_moving = 1'b0;
        if (q_count != 0) begin
          q_head = q_head + 4'd1;
          q_count = q_count - 5'd1;
        end
        r.event_code = EV_STOPPED;
      end
      OP_EMERG_ON: begin
        emerg_on = 1'b1;
        goal_at = car_at;
        car_moving = 1'b0;
        q_head = '0;
        q_tail = '0;
        q_count = '0;
        r.event_code = EV_WARNING;
      end
      OP_EMERG_OFF: begin
        emerg_on = 1'b0;
        r.event_code = EV_RESUME;
      end
      default: ;
    endcase
    r.motor_cw = heading_up;
    r.motor_on = car_moving;
    r.car_floor = car_at;
    r.goal_fl = goal_at;
    r.pending = q_count;
    r.alarm = emerg_on;
    return r;
  endfunction

  function automatic logic [FloorWidth-1:0] any_floor();
    return FloorWidth'($urandom_range(FloorCount - 1));
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [FloorWidth-1:0] fl);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    floor_i <= fl;
    do @(posedge clk_i); while (!in_ready_o);
    reports_due.push_back(car_response(op, fl));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_queue_limit(input logic [CountWidth-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    q_limit = v;
    cfg_we_i <= 1'b0;
  endtask

  // mostly request bursts followed by a full trip, plus emergencies and noise
  task automatic run_trips(input int unsigned n_words);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned burst;
    int unsigned span;
    logic [FloorWidth-1:0] fl;
    logic [FloorWidth-1:0] last_fl;
    stop_at = items_sent + n_words;
    last_fl = '0;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_word(3'($urandom_range(7)), any_floor());
      end else if (pick < 17) begin
        send_word(OP_START, any_floor());
        repeat ($urandom_range(2)) send_word(OP_STEP, any_floor());
        send_word(OP_EMERG_ON, any_floor());
        repeat ($urandom_range(3)) send_word(OP_REQUEST, any_floor());
        send_word(OP_STEP, any_floor());
        send_word(OP_EMERG_OFF, any_floor());
      end else begin
        burst = ($urandom_range(3) == 0) ? $urandom_range(8, 20) : $urandom_range(4);
        repeat (burst) begin
          fl = ($urandom_range(4) == 0) ? last_fl : any_floor();
          send_word(OP_REQUEST, fl);
          last_fl = fl;
        end
        send_word(OP_START, any_floor());
        span = (car_at > goal_at) ? car_at - goal_at : goal_at - car_at;
        repeat (span + $urandom_range(2)) send_word(OP_STEP, any_floor());
        repeat ($urandom_range(1, 2)) send_word(OP_STOP, any_floor());
      end
    end
  endtask

  task automatic test_directed_ops();
    send_word(OP_REQUEST, 4'd0);
    send_word(OP_REQUEST, 4'd15);
    send_word(OP_REQUEST, 4'd15);
    send_word(OP_REQUEST, 4'd0);
    send_word(OP_START, 4'd0);
    send_word(OP_STEP, 4'd15);
    send_word(OP_STEP, 4'd0);
    send_word(OP_STOP, 4'd15);
    send_word(OP_START, 4'd0);
    send_word(OP_STEP, 4'd0);
    send_word(OP_STEP, 4'd0);
    send_word(OP_STEP, 4'd0);
    send_word(OP_STOP, 4'd0);
    send_word(OP_START, 4'd15);
    send_word(OpSpareLo, 4'd0);
    send_word(OpSpareHi, 4'd15);
    send_word(OP_REQUEST, 4'd10);
    send_word(OP_EMERG_ON, 4'd0);
    send_word(OP_REQUEST, 4'd3);
    send_word(OP_EMERG_ON, 4'd0);
    send_word(OP_STEP, 4'd0);
    send_word(OP_EMERG_OFF, 4'd0);
    send_word(OP_STOP, 4'd0);
    send_word(OP_REQUEST, 4'd5);
    send_word(OP_START, 4'd0);
    drain_results();
  endtask

  task automatic test_random_trips(input logic [CountWidth-1:0] lim,
                                   input int unsigned send_pct,
                                   input int unsigned recv_pct,
                                   input int unsigned n_words);
    set_queue_limit(lim);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    run_trips(n_words);
    drain_results();
  endtask

  // long output stall so the block backs up into its input
  task automatic test_backpressure();
    set_queue_limit(5'd1);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_asked++;
    run_trips(40);
    drain_results();
  endtask

  always @(posedge clk_i) begin
    if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left <= HoldLen;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  task automatic check_field(input string label, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, label, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    car_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reports_due.size() == 0) begin
        mismatches++;
        $display("%0t: word out with nothing expected, event %0d", $time, event_res_o);
      end else begin
        want = reports_due.pop_front();
        check_field("event_res", want.event_code, event_res_o);
        check_field("event_floor", want.event_floor, event_floor_o);
        check_field("arrived", want.arrived, arrived_o);
        check_field("motor_cw", want.motor_cw, motor_cw_o);
        check_field("motor_on", want.motor_on, motor_on_o);
        check_field("current_floor", want.car_floor, current_floor_o);
        check_field("target_floor", want.goal_fl, target_floor_o);
        check_field("pending", want.pending, pending_o);
        check_field("alarm", want.alarm, alarm_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, reports_due.size());
      $display("** elevator_request_controller: FAILED **");
      $finish;
    end
  end

  initial begin
    send_gap_pct = 8;
    recv_gap_pct = 73;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_random_trips(5'd31, 8, 73, 300);
    test_random_trips(5'd3, 73, 8, 250);
    test_random_trips(5'd0, 0, 0, 60);
    test_random_trips(5'd16, 0, 0, 250);
    test_backpressure();
    if (mismatches == 0)
      $display("** elevator_request_controller: PASSED **");
    else
      $display("** elevator_request_controller: FAILED **");
    $finish;
  end

endmodule
